// ===== src/kpi_pkg.sv =====
// Shared types and constants for the keyframe pose interpolator.
`default_nettype none
package kpi_pkg;

   // Request kinds
   localparam logic [2:0] KIND_HEADER = 3'd0;
   localparam logic [2:0] KIND_SPAN   = 3'd1;
   localparam logic [2:0] KIND_POSE   = 3'd2;
   localparam logic [2:0] KIND_SELECT = 3'd3;
   localparam logic [2:0] KIND_TICK   = 3'd4;

   localparam int unsigned MOTIONS = 8;
   localparam int unsigned KEYS    = 16;
   localparam int unsigned PARTS   = 16;

   // Axis code that addresses nothing
   localparam logic [1:0] AXIS_NONE = 2'd3;
   localparam logic [1:0] AXIS_LAST = 2'd2;

   // Pi and 2pi in Q3.12
   localparam logic signed [17:0] PI_Q     = 18'sd12868;
   localparam logic signed [17:0] TWO_PI_Q = 18'sd25736;

   // Restoring divider steps, one quotient bit each
   localparam logic [4:0] DIV_LAST = 5'd23;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEL,
      ST_SELSET,
      ST_RDA,
      ST_RDB,
      ST_CAPB,
      ST_MUL,
      ST_DIV,
      ST_SUM,
      ST_EMIT,
      ST_SPAN,
      ST_ADV
   } state_type;

endpackage
`default_nettype wire

// ===== src/keyframe_pose_interpolator.sv =====
// Keyframe pose interpolator: pose stores, tick sequencer and shared mul/div unit.
`default_nettype none
//  channel | ports                         | direction
//  req     | req_valid / req_stall + fields | in, stall driven here
//  rsp     | rsp_valid / rsp_stall + fields | out, stall driven by sink
//  csr     | csr_we / csr_wdata (part_count)| in, no wait
// Loads leave the sequencer idle; select passes ST_SEL and ST_SELSET. A playing tick
// runs each part in turn, then ST_SPAN and ST_ADV. Each axis reads both keys (ST_RDA,
// ST_RDB, ST_CAPB), then runs multiply, 24-step restoring divider and sum on
// position and again on angle. Each part ends in ST_EMIT, held while its result
// is stalled. An idle tick only passes ST_EMIT. Reset is synchronous and clears
// control only; the pose and span memories hold garbage until loaded. A stalled
// result holds the sequencer; no request is taken until the whole tick is delivered.
module keyframe_pose_interpolator
   import kpi_pkg::*;
(
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire  [2:0]         req_kind,
   input  wire  [2:0]         req_motion,
   input  wire  [3:0]         req_key,
   input  wire  [3:0]         req_part,
   input  wire  [1:0]         req_axis,
   input  wire                req_loop_flag,
   input  wire  [4:0]         req_key_total,
   input  wire  [7:0]         req_span_frames,
   input  wire  signed [15:0] req_position_value,
   input  wire  signed [15:0] req_angle_value,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic [3:0]         rsp_part_index,
   output logic signed [15:0] rsp_offset_x,
   output logic signed [15:0] rsp_offset_y,
   output logic signed [15:0] rsp_offset_z,
   output logic signed [15:0] rsp_turn_x,
   output logic signed [15:0] rsp_turn_y,
   output logic signed [15:0] rsp_turn_z,
   output logic               rsp_last_part,
   output logic               rsp_playing,
   output logic               rsp_finished,
   input  wire                csr_we,
   input  wire  [4:0]         csr_wdata
);

   state_type state_ff, state_in;
   logic [4:0]  part_count_ff;
   logic        loop_ff [MOTIONS];
   logic [4:0]  ktot_ff [MOTIONS];
   logic [2:0]  motion_ff, motion_in;
   logic [3:0]  key_ff, key_in;
   logic [7:0]  frame_ff, frame_in;
   logic [7:0]  span_ff, span_in;
   logic        active_ff, active_in;
   logic        done_ff, done_in;
   logic [3:0]  ck_ff, ck_in;
   logic [2:0]  tm_ff, tm_in;
   logic [3:0]  tk_ff, tk_in;
   logic [4:0]  n_ff, n_in;
   logic        lastkey_ff, lastkey_in;
   logic [3:0]  part_ff, part_in;
   logic [1:0]  axis_ff, axis_in;
   logic        sel_ff, sel_in;
   logic signed [15:0] pa_ff, pa_in, ra_ff, ra_in;
   logic signed [16:0] dpos_ff, dpos_in, dang_ff, dang_in;
   logic        neg_ff, neg_in;
   logic [7:0]  rem_ff, rem_in;
   logic [23:0] dq_ff, dq_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic signed [15:0] off_ff [3];
   logic signed [15:0] off_in [3];
   logic signed [15:0] turn_ff [3];
   logic signed [15:0] turn_in [3];
   logic        rvalid_ff, rvalid_in;
   logic        rlast_ff, rlast_in;
   logic        rplay_ff, rplay_in;
   logic        rfin_ff, rfin_in;

   // Memories
   logic [15:0] pos_mem [8192];
   logic [15:0] ang_mem [8192];
   logic [7:0]  span_mem [128];
   logic [15:0] pos_rd_ff, ang_rd_ff;
   logic [7:0]  span_rd_ff;
   logic [12:0] pose_waddr, pose_raddr;
   logic [6:0]  span_raddr;
   logic        req_take;

   assign req_take   = req_valid && (state_ff == ST_IDLE);
   assign req_stall  = (state_ff != ST_IDLE);
   assign pose_waddr = {req_motion, req_key, req_part, req_axis};
   assign pose_raddr = (state_ff == ST_RDA) ? {motion_ff, ck_ff, part_ff, axis_ff}
                                            : {tm_ff, tk_ff, part_ff, axis_ff};
   assign span_raddr = (state_ff == ST_SEL) ? {motion_ff, 4'd0} : {motion_ff, tk_ff};

   // Pose stores
   always_ff @(posedge clock) begin
      if (req_take && req_kind == KIND_POSE && req_axis != AXIS_NONE) begin
         pos_mem[pose_waddr] <= req_position_value;
         ang_mem[pose_waddr] <= req_angle_value;
      end
      pos_rd_ff <= pos_mem[pose_raddr];
      ang_rd_ff <= ang_mem[pose_raddr];
   end

   // Span store, zero loads as one
   always_ff @(posedge clock) begin
      if (req_take && req_kind == KIND_SPAN) begin
         span_mem[{req_motion, req_key}] <= (req_span_frames == 8'd0) ? 8'd1 : req_span_frames;
      end
      span_rd_ff <= span_mem[span_raddr];
   end

   // Motion headers, key count clamped to 1..KEYS
   always_ff @(posedge clock) begin
      if (req_take && req_kind == KIND_HEADER) begin
         loop_ff[req_motion] <= req_loop_flag;
         if (req_key_total == 5'd0) begin
            ktot_ff[req_motion] <= 5'd1;
         end else if (req_key_total > 5'(KEYS)) begin
            ktot_ff[req_motion] <= 5'(KEYS);
         end else begin
            ktot_ff[req_motion] <= req_key_total;
         end
      end
   end

   // Datapath helpers
   logic [4:0]  total;
   logic        is_last;
   logic [4:0]  ck_full;
   logic signed [17:0] dpos_w, dang_w;
   logic signed [16:0] dsel;
   logic signed [25:0] prod;
   logic [25:0] prod_mag;
   logic [8:0]  trial;
   logic        ge;
   logic signed [17:0] quot;
   logic signed [18:0] sum;
   logic signed [15:0] base, sat;

   always_comb begin
      total   = ktot_ff[motion_ff];
      is_last = ({1'b0, key_ff} + 5'd1) >= total;
      ck_full = is_last ? (total - 5'd1) : {1'b0, key_ff};

      dpos_w = 18'(signed'(pos_rd_ff)) - 18'(pa_ff);
      dang_w = 18'(signed'(ang_rd_ff)) - 18'(ra_ff);
      if (dang_w > PI_Q) begin
         dang_w = dang_w - TWO_PI_Q;
      end else if (dang_w < -PI_Q) begin
         dang_w = dang_w + TWO_PI_Q;
      end

      dsel     = sel_ff ? dang_ff : dpos_ff;
      prod     = 26'(dsel) * 26'(signed'({1'b0, frame_ff}));
      prod_mag = prod[25] ? 26'(-prod) : 26'(prod);

      trial = {rem_ff, dq_ff[23]};
      ge    = trial >= {1'b0, span_ff};

      quot = neg_ff ? -18'(signed'({1'b0, dq_ff[16:0]})) : 18'(signed'({1'b0, dq_ff[16:0]}));
      base = sel_ff ? ra_ff : pa_ff;
      sum  = 19'(base) + 19'(quot);
      if (sum > 19'sd32767) begin
         sat = 16'sh7fff;
      end else if (sum < -19'sd32768) begin
         sat = 16'sh8000;
      end else begin
         sat = sum[15:0];
      end
   end

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      motion_in  = motion_ff;
      key_in     = key_ff;
      frame_in   = frame_ff;
      span_in    = span_ff;
      active_in  = active_ff;
      done_in    = done_ff;
      ck_in      = ck_ff;
      tm_in      = tm_ff;
      tk_in      = tk_ff;
      n_in       = n_ff;
      lastkey_in = lastkey_ff;
      part_in    = part_ff;
      axis_in    = axis_ff;
      sel_in     = sel_ff;
      pa_in      = pa_ff;
      ra_in      = ra_ff;
      dpos_in    = dpos_ff;
      dang_in    = dang_ff;
      neg_in     = neg_ff;
      rem_in     = rem_ff;
      dq_in      = dq_ff;
      cnt_in     = cnt_ff;
      off_in     = off_ff;
      turn_in    = turn_ff;
      rvalid_in  = rvalid_ff;
      rlast_in   = rlast_ff;
      rplay_in   = rplay_ff;
      rfin_in    = rfin_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take && req_kind == KIND_SELECT) begin
               motion_in = req_motion;
               key_in    = 4'd0;
               frame_in  = 8'd0;
               done_in   = 1'b0;
               active_in = 1'b1;
               state_in  = ST_SEL;
            end else if (req_take && req_kind == KIND_TICK) begin
               if (!active_ff) begin
                  part_in   = 4'd0;
                  off_in    = '{default: 16'sd0};
                  turn_in   = '{default: 16'sd0};
                  rlast_in  = 1'b1;
                  rplay_in  = 1'b0;
                  rfin_in   = done_ff;
                  rvalid_in = 1'b1;
                  state_in  = ST_EMIT;
               end else begin
                  ck_in      = ck_full[3:0];
                  lastkey_in = is_last;
                  tm_in      = (is_last && !loop_ff[motion_ff]) ? 3'd0 : motion_ff;
                  tk_in      = is_last ? 4'd0 : (ck_full[3:0] + 4'd1);
                  if (part_count_ff == 5'd0) begin
                     n_in = 5'd1;
                  end else if (part_count_ff > 5'(PARTS)) begin
                     n_in = 5'(PARTS);
                  end else begin
                     n_in = part_count_ff;
                  end
                  part_in  = 4'd0;
                  axis_in  = 2'd0;
                  sel_in   = 1'b0;
                  state_in = ST_RDA;
               end
            end
         end
         ST_SEL:    state_in = ST_SELSET;
         ST_SELSET: begin
            span_in  = span_rd_ff;
            state_in = ST_IDLE;
         end
         ST_RDA: state_in = ST_RDB;
         ST_RDB: begin
            pa_in    = signed'(pos_rd_ff);
            ra_in    = signed'(ang_rd_ff);
            state_in = ST_CAPB;
         end
         ST_CAPB: begin
            dpos_in  = dpos_w[16:0];
            dang_in  = dang_w[16:0];
            state_in = ST_MUL;
         end
         ST_MUL: begin
            neg_in   = prod[25];
            dq_in    = prod_mag[23:0];
            rem_in   = 8'd0;
            cnt_in   = 5'd0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = ge ? 8'(trial - {1'b0, span_ff}) : trial[7:0];
            dq_in  = {dq_ff[22:0], ge};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (sel_ff) begin
               turn_in[axis_ff] = sat;
            end else begin
               off_in[axis_ff] = sat;
            end
            if (!sel_ff) begin
               sel_in   = 1'b1;
               state_in = ST_MUL;
            end else begin
               sel_in = 1'b0;
               if (axis_ff == AXIS_LAST) begin
                  axis_in   = 2'd0;
                  rlast_in  = ({1'b0, part_ff} + 5'd1) == n_ff;
                  rplay_in  = 1'b1;
                  rfin_in   = 1'b0;
                  rvalid_in = 1'b1;
                  state_in  = ST_EMIT;
               end else begin
                  axis_in  = axis_ff + 2'd1;
                  state_in = ST_RDA;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               rvalid_in = 1'b0;
               if (!rplay_ff) begin
                  state_in = ST_IDLE;
               end else if (rlast_ff) begin
                  state_in = ST_SPAN;
               end else begin
                  part_in  = part_ff + 4'd1;
                  state_in = ST_RDA;
               end
            end
         end
         ST_SPAN: state_in = ST_ADV;
         ST_ADV: begin
            if (({1'b0, frame_ff} + 9'd1) >= {1'b0, span_ff}) begin
               frame_in = 8'd0;
               if (lastkey_ff && !loop_ff[motion_ff]) begin
                  done_in   = 1'b1;
                  active_in = 1'b0;
               end else begin
                  key_in  = tk_ff;
                  span_in = span_rd_ff;
               end
            end else begin
               frame_in = frame_ff + 8'd1;
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         part_count_ff <= 5'd1;
         motion_ff     <= 3'd0;
         key_ff        <= 4'd0;
         frame_ff      <= 8'd0;
         span_ff       <= 8'd1;
         active_ff     <= 1'b0;
         done_ff       <= 1'b0;
         rvalid_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         if (csr_we) begin
            part_count_ff <= csr_wdata;
         end
         motion_ff <= motion_in;
         key_ff    <= key_in;
         frame_ff  <= frame_in;
         span_ff   <= span_in;
         active_ff <= active_in;
         done_ff   <= done_in;
         rvalid_ff <= rvalid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ck_ff      <= ck_in;
      tm_ff      <= tm_in;
      tk_ff      <= tk_in;
      n_ff       <= n_in;
      lastkey_ff <= lastkey_in;
      part_ff    <= part_in;
      axis_ff    <= axis_in;
      sel_ff     <= sel_in;
      pa_ff      <= pa_in;
      ra_ff      <= ra_in;
      dpos_ff    <= dpos_in;
      dang_ff    <= dang_in;
      neg_ff     <= neg_in;
      rem_ff     <= rem_in;
      dq_ff      <= dq_in;
      cnt_ff     <= cnt_in;
      off_ff     <= off_in;
      turn_ff    <= turn_in;
      rlast_ff   <= rlast_in;
      rplay_ff   <= rplay_in;
      rfin_ff    <= rfin_in;
   end

   assign rsp_valid      = rvalid_ff;
   assign rsp_part_index = part_ff;
   assign rsp_offset_x   = off_ff[0];
   assign rsp_offset_y   = off_ff[1];
   assign rsp_offset_z   = off_ff[2];
   assign rsp_turn_x     = turn_ff[0];
   assign rsp_turn_y     = turn_ff[1];
   assign rsp_turn_z     = turn_ff[2];
   assign rsp_last_part  = rlast_ff;
   assign rsp_playing    = rplay_ff;
   assign rsp_finished   = rfin_ff;

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the keyframe pose interpolator.
`default_nettype none
module tb_top;
   import kpi_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int TICK_SETTLE = 3000;

   typedef struct {
      logic [2:0]         kind;
      logic [2:0]         motion;
      logic [3:0]         key;
      logic [3:0]         part;
      logic [1:0]         axis;
      logic               loop_flag;
      logic [4:0]         key_total;
      logic [7:0]         span;
      logic signed [15:0] pos;
      logic signed [15:0] ang;
   } anim_req_type;

   typedef struct {
      logic [3:0]         part_index;
      logic signed [15:0] off [3];
      logic signed [15:0] turn [3];
      logic               last_part;
      logic               playing;
      logic               finished;
   } pose_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_kind = '0;
   logic [2:0] req_motion = '0;
   logic [3:0] req_key = '0;
   logic [3:0] req_part = '0;
   logic [1:0] req_axis = '0;
   logic req_loop_flag = 1'b0;
   logic [4:0] req_key_total = '0;
   logic [7:0] req_span_frames = '0;
   logic signed [15:0] req_position_value = '0;
   logic signed [15:0] req_angle_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [3:0] rsp_part_index;
   logic signed [15:0] rsp_offset_x, rsp_offset_y, rsp_offset_z;
   logic signed [15:0] rsp_turn_x, rsp_turn_y, rsp_turn_z;
   logic rsp_last_part, rsp_playing, rsp_finished;
   logic csr_we = 1'b0;
   logic [4:0] csr_wdata = '0;

   keyframe_pose_interpolator dut (
      .clock, .reset, .req_valid, .req_stall, .req_kind, .req_motion, .req_key,
      .req_part, .req_axis, .req_loop_flag, .req_key_total, .req_span_frames,
      .req_position_value, .req_angle_value, .rsp_valid, .rsp_stall,
      .rsp_part_index, .rsp_offset_x, .rsp_offset_y, .rsp_offset_z,
      .rsp_turn_x, .rsp_turn_y, .rsp_turn_z, .rsp_last_part, .rsp_playing,
      .rsp_finished, .csr_we, .csr_wdata
   );

   // clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   anim_req_type req_pending [$];
   pose_type     pose_expect [$];
   int        mismatches = 0;
   int        cycles = 0;
   bit        quiet = 1'b0;
   int        item_count = 0;

   // shadow of the animation state
   logic signed [15:0] pos_mem [8][16][16][3];
   logic signed [15:0] ang_mem [8][16][16][3];
   bit                 pose_wr [8][16][16][3];
   int                 span_mem [8][16];
   bit                 span_wr [8][16];
   int                 keys_mem [8];
   bit                 loop_mem [8];
   bit                 hdr_wr [8];
   int                 cur_motion = 0, cur_key = 0, frame_cnt = 0, cur_span = 1;
   bit                 active = 0, done = 0;
   int                 part_cnt = 1;

   function automatic logic signed [15:0] sat16(int v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   function automatic int blend(int a, int d);
      return a + (d * frame_cnt) / cur_span;
   endfunction

   function automatic int parts_now();
      if (part_cnt < 1) return 1;
      if (part_cnt > PARTS) return PARTS;
      return part_cnt;
   endfunction

   // apply one request to the shadow state and queue its poses
   task automatic animate(anim_req_type r);
      int t, total, ck, tm, tk, n, dr, pa, pb, ra, rb;
      bit last;
      pose_type o;
      case (r.kind)
         KIND_HEADER: begin
            t = r.key_total;
            if (t == 0) t = 1;
            if (t > KEYS) t = KEYS;
            loop_mem[r.motion] = r.loop_flag;
            keys_mem[r.motion] = t;
            hdr_wr[r.motion] = 1;
         end
         KIND_SPAN: begin
            span_mem[r.motion][r.key] = (r.span == 0) ? 1 : r.span;
            span_wr[r.motion][r.key] = 1;
         end
         KIND_POSE: begin
            if (r.axis != AXIS_NONE) begin
               pos_mem[r.motion][r.key][r.part][r.axis] = r.pos;
               ang_mem[r.motion][r.key][r.part][r.axis] = r.ang;
               pose_wr[r.motion][r.key][r.part][r.axis] = 1;
            end
         end
         KIND_SELECT: begin
            cur_motion = r.motion;
            cur_key = 0;
            frame_cnt = 0;
            done = 0;
            active = 1;
            cur_span = span_mem[r.motion][0];
         end
         KIND_TICK: begin
            if (!active) begin
               o.part_index = '0;
               for (int a = 0; a < 3; a++) begin
                  o.off[a] = '0;
                  o.turn[a] = '0;
               end
               o.last_part = 1;
               o.playing = 0;
               o.finished = done;
               pose_expect.push_back(o);
            end else begin
               total = keys_mem[cur_motion];
               last = cur_key + 1 >= total;
               ck = last ? total - 1 : cur_key;
               tm = cur_motion;
               tk = last ? 0 : ck + 1;
               if (last && !loop_mem[cur_motion]) tm = 0;
               n = parts_now();
               for (int i = 0; i < n; i++) begin
                  o.part_index = i[3:0];
                  for (int a = 0; a < 3; a++) begin
                     pa = pos_mem[cur_motion][ck][i][a];
                     pb = pos_mem[tm][tk][i][a];
                     ra = ang_mem[cur_motion][ck][i][a];
                     rb = ang_mem[tm][tk][i][a];
                     dr = rb - ra;
                     if (dr > PI_Q) dr -= TWO_PI_Q;
                     else if (dr < -PI_Q) dr += TWO_PI_Q;
                     o.off[a] = sat16(blend(pa, pb - pa));
                     o.turn[a] = sat16(blend(ra, dr));
                  end
                  o.last_part = (i + 1 == n);
                  o.playing = 1;
                  o.finished = 0;
                  pose_expect.push_back(o);
               end
               // advance frame and key
               if (frame_cnt + 1 >= cur_span) begin
                  frame_cnt = 0;
                  if (ck + 1 >= total) begin
                     if (!loop_mem[cur_motion]) begin
                        done = 1;
                        active = 0;
                     end else begin
                        cur_key = 0;
                        cur_span = span_mem[cur_motion][0];
                     end
                  end else begin
                     cur_key = ck + 1;
                     cur_span = span_mem[cur_motion][ck + 1];
                  end
               end else begin
                  frame_cnt++;
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic send(anim_req_type r);
      animate(r);
      req_pending.push_back(r);
      item_count++;
   endtask

   function automatic logic signed [15:0] rand_value();
      case ($urandom_range(0, 5))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic anim_req_type blank(logic [2:0] kind);
      anim_req_type r;
      r.kind = kind;
      r.motion = 3'($urandom);
      r.key = 4'($urandom);
      r.part = 4'($urandom);
      r.axis = 2'($urandom_range(0, 2));
      r.loop_flag = 1'($urandom);
      r.key_total = 5'($urandom);
      r.span = 8'($urandom);
      r.pos = 16'($urandom);
      r.ang = 16'($urandom);
      return r;
   endfunction

   task automatic load_header(int m, bit lp, int total);
      anim_req_type r;
      r = blank(KIND_HEADER);
      r.motion = 3'(m);
      r.loop_flag = lp;
      r.key_total = 5'(total);
      send(r);
   endtask

   task automatic load_span(int m, int k, int s);
      anim_req_type r;
      r = blank(KIND_SPAN);
      r.motion = 3'(m);
      r.key = 4'(k);
      r.span = 8'(s);
      send(r);
   endtask

   task automatic load_pose(int m, int k, int p, int a, logic signed [15:0] pv,
                            logic signed [15:0] av);
      anim_req_type r;
      r = blank(KIND_POSE);
      r.motion = 3'(m);
      r.key = 4'(k);
      r.part = 4'(p);
      r.axis = 2'(a);
      r.pos = pv;
      r.ang = av;
      send(r);
   endtask

   // select, loading header and first span first if never written
   task automatic select_motion(int m);
      anim_req_type r;
      if (!hdr_wr[m]) load_header(m, 1'($urandom), $urandom_range(1, 3));
      if (!span_wr[m][0]) load_span(m, 0, $urandom_range(0, 3));
      r = blank(KIND_SELECT);
      r.motion = 3'(m);
      send(r);
   endtask

   // tick, loading any pose or span that the tick would read unwritten
   task automatic tick();
      int total, ck, tm, tk, nk;
      bit last;
      if (active) begin
         total = keys_mem[cur_motion];
         last = cur_key + 1 >= total;
         ck = last ? total - 1 : cur_key;
         tm = cur_motion;
         tk = last ? 0 : ck + 1;
         if (last && !loop_mem[cur_motion]) tm = 0;
         for (int i = 0; i < parts_now(); i++)
            for (int a = 0; a < 3; a++) begin
               if (!pose_wr[cur_motion][ck][i][a])
                  load_pose(cur_motion, ck, i, a, rand_value(), rand_value());
               if (!pose_wr[tm][tk][i][a])
                  load_pose(tm, tk, i, a, rand_value(), rand_value());
            end
         if (frame_cnt + 1 >= cur_span) begin
            nk = (ck + 1 >= total) ? (loop_mem[cur_motion] ? 0 : -1) : ck + 1;
            if (nk >= 0 && !span_wr[cur_motion][nk])
               load_span(cur_motion, nk, $urandom_range(0, 3));
         end
      end
      send(blank(KIND_TICK));
   endtask

   task automatic drain();
      while (req_pending.size() != 0 || req_valid || pose_expect.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_part_count(logic [4:0] v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      part_cnt = v;
   endtask

   // random phase: mostly well-formed play sequences, some noise
   task automatic random_phase(int count);
      anim_req_type r;
      int stop, m, total;
      stop = item_count + count;
      while (item_count < stop) begin
         case ($urandom_range(0, 9))
            0: begin
               r = blank(3'($urandom_range(0, 7)));
               if (r.kind == KIND_POSE && $urandom_range(0, 1)) r.axis = AXIS_NONE;
               if (r.kind == KIND_SELECT) select_motion(r.motion);
               else if (r.kind == KIND_TICK) tick();
               else send(r);
            end
            1, 2: begin
               m = $urandom_range(0, 7);
               total = $urandom_range(0, 5) == 0 ? $urandom : $urandom_range(1, 3);
               load_header(m, 1'($urandom), total);
               for (int k = 0; k < 3; k++)
                  load_span(m, k, $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 3));
               select_motion(m);
            end
            default: tick();
         endcase
      end
   endtask

   // request driver
   bit req_taken = 0;
   int req_gap = 0;
   always @(posedge clock) req_taken <= !reset && req_valid && !req_stall;

   always @(negedge clock) begin
      if (!req_valid || req_taken) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (req_pending.size() > 0 && !reset) begin
            anim_req_type r;
            r = req_pending.pop_front();
            req_kind <= r.kind;
            req_motion <= r.motion;
            req_key <= r.key;
            req_part <= r.part;
            req_axis <= r.axis;
            req_loop_flag <= r.loop_flag;
            req_key_total <= r.key_total;
            req_span_frames <= r.span;
            req_position_value <= r.pos;
            req_angle_value <= r.ang;
            req_valid <= 1'b1;
            if (!quiet && $urandom_range(0, 5) == 0) req_gap <= $urandom_range(1, 17);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result stall bursts
   int rsp_gap = 0;
   always @(negedge clock) begin
      if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         rsp_gap <= $urandom_range(0, 16);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // pose monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         pose_type want;
         if (pose_expect.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected pose for part %0d", rsp_part_index);
         end else begin
            want = pose_expect.pop_front();
            if (rsp_part_index !== want.part_index || rsp_offset_x !== want.off[0] ||
                rsp_offset_y !== want.off[1] || rsp_offset_z !== want.off[2] ||
                rsp_turn_x !== want.turn[0] || rsp_turn_y !== want.turn[1] ||
                rsp_turn_z !== want.turn[2] || rsp_last_part !== want.last_part ||
                rsp_playing !== want.playing || rsp_finished !== want.finished) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("pose mismatch exp p%0d off %0d %0d %0d turn %0d %0d %0d l%b p%b f%b",
                           want.part_index, want.off[0], want.off[1], want.off[2],
                           want.turn[0], want.turn[1], want.turn[2], want.last_part,
                           want.playing, want.finished, "\n",
                           "               got p%0d off %0d %0d %0d turn %0d %0d %0d l%b p%b f%b",
                           rsp_part_index, rsp_offset_x, rsp_offset_y, rsp_offset_z,
                           rsp_turn_x, rsp_turn_y, rsp_turn_z, rsp_last_part,
                           rsp_playing, rsp_finished);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("keyframe_pose_interpolator test failed");
         $finish;
      end
   end

   // stimulus sequence
   initial begin
      logic [4:0] settings [6];
      settings = '{5'd16, 5'd0, 5'd3, 5'd31, 5'd2, 5'd1};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: idle tick, clamps, extremes, shortest arc, saturation, end
      tick();
      load_header(0, 0, 2);
      load_header(1, 1, 0);
      load_header(2, 0, 31);
      load_span(0, 0, 4);
      load_span(0, 1, 0);
      load_pose(0, 0, 0, 0, 16'sh8000, 16'sd32000);
      load_pose(0, 1, 0, 0, 16'sh7fff, 16'sd10000);
      load_pose(0, 0, 0, 1, 16'sh7fff, -16'sd12000);
      load_pose(0, 1, 0, 1, 16'sh8000, 16'sd12000);
      load_pose(0, 0, 0, 2, 16'sd0, 16'sh8000);
      load_pose(0, 1, 0, 2, -16'sd1, 16'sh7fff);
      load_pose(0, 0, 0, AXIS_NONE, 16'sd5, 16'sd5);
      send(blank(3'd6));
      select_motion(0);
      repeat (6) tick();
      select_motion(1);
      repeat (2) tick();
      load_header(3, 1, 3);
      select_motion(3);
      tick();
      load_header(3, 1, 1);
      tick();
      drain();

      // random phases across register settings, the last one without idling
      for (int s = 0; s < 6; s++) begin
         write_part_count(settings[s]);
         random_phase(s == 0 ? 20 : 55);
         drain();
      end
      write_part_count(5'($urandom_range(1, 4)));
      quiet = 1'b1;
      random_phase(40);
      drain();
      repeat (TICK_SETTLE) @(posedge clock);

      if (mismatches == 0 && pose_expect.size() == 0)
         $display("keyframe_pose_interpolator test passed");
      else
         $display("keyframe_pose_interpolator test failed");
      $finish;
   end

endmodule
`default_nettype wire
